>>> hw/rtl/scroll_snap_select_unit_assert.svh
// Assertion macros used by the scroll snap select core.
`ifndef SCROLL_SNAP_SELECT_UNIT_ASSERT_SVH
`define SCROLL_SNAP_SELECT_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define SSNAP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define SSNAP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/ssnap_pkg.sv
// Package: types, codes and helpers for the scroll snap select unit.
`timescale 1ns / 1ps
package ssnap_pkg;

  localparam int ALU_W      = 34;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;
  localparam int MUL_CNT_W  = 4;
  localparam logic [MUL_CNT_W-1:0] MUL_LAST = '1;

  localparam logic [1:0] FUNC_BEGIN  = 2'd0;
  localparam logic [1:0] FUNC_CAND   = 2'd1;
  localparam logic [1:0] FUNC_FINISH = 2'd2;

  localparam logic [1:0] ALIGN_START  = 2'd0;
  localparam logic [1:0] ALIGN_END    = 2'd1;
  localparam logic [1:0] ALIGN_CENTER = 2'd2;

  localparam logic [1:0] OUT_KEPT = 2'd0;
  localparam logic [1:0] OUT_SNAP = 2'd1;
  localparam logic [1:0] OUT_STOP = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROXIMITY_NUM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROXIMITY_DEN = 2'd2;

  localparam logic [22:0] LIMIT_RESET = 23'd32767;
  localparam logic [7:0]  NUM_RESET   = 8'd1;
  localparam logic [7:0]  DEN_RESET   = 8'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [23:0] cur_offset;
    logic signed [23:0] want_offset;
    logic signed [23:0] view_top;
    logic signed [23:0] view_bottom;
    logic [22:0]        scroll_range;
    logic               snap_on;
    logic               mandatory;
    logic signed [23:0] box_top;
    logic signed [23:0] box_bottom;
    logic [1:0]         align;
    logic               stop_always;
  } ssnap_item_t;

  typedef struct packed {
    logic signed [23:0] settled_offset;
    logic [1:0]         outcome;
  } ssnap_result_t;

  typedef struct packed {
    logic [22:0] scroll_limit;
    logic [7:0]  proximity_num;
    logic [7:0]  proximity_den;
  } ssnap_cfg_t;

  typedef struct packed {
    logic inv_b;
    logic cin;
  } ssnap_alu_op_t;

  typedef struct packed {
    logic signed [ALU_W-1:0] sum;
    logic                    neg;
    logic                    zero;
  } ssnap_alu_res_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_BEGIN,
    ST_C_DELTA,
    ST_C_H1,
    ST_C_U,
    ST_C_H2,
    ST_C_D,
    ST_C_CAND,
    ST_C_CLAMP,
    ST_C_DIST,
    ST_C_ABS,
    ST_C_BEST,
    ST_C_MOVE,
    ST_C_TRAV,
    ST_C_PATH,
    ST_C_TABS,
    ST_C_STOP,
    ST_F_H,
    ST_F_MUL
  } ssnap_state_t;

  localparam ssnap_alu_op_t OP_ADD = '{inv_b: 1'b0, cin: 1'b0};
  localparam ssnap_alu_op_t OP_SUB = '{inv_b: 1'b1, cin: 1'b1};

  function automatic logic signed [ALU_W-1:0] sext24(input logic [23:0] v);
    return {{(ALU_W-24){v[23]}}, v};
  endfunction

  function automatic logic signed [ALU_W-1:0] sext25(input logic [24:0] v);
    return {{(ALU_W-25){v[24]}}, v};
  endfunction

  function automatic logic signed [ALU_W-1:0] zext25(input logic [24:0] v);
    return {{(ALU_W-25){1'b0}}, v};
  endfunction

  function automatic logic signed [ALU_W-1:0] zext23(input logic [22:0] v);
    return {{(ALU_W-23){1'b0}}, v};
  endfunction

  // Arithmetic halving of a value already biased for truncation toward zero.
  function automatic logic signed [ALU_W-1:0] half(input logic [ALU_W-1:0] v);
    return {v[ALU_W-1], v[ALU_W-1:1]};
  endfunction

endpackage

>>> hw/rtl/ssnap_alu.sv
// Shared add/subtract unit with sign and zero flags.
`timescale 1ns / 1ps
module ssnap_alu (
  input  logic signed [ssnap_pkg::ALU_W-1:0] a,
  input  logic signed [ssnap_pkg::ALU_W-1:0] b,
  input  ssnap_pkg::ssnap_alu_op_t           op,
  output ssnap_pkg::ssnap_alu_res_t          res
);
  import ssnap_pkg::*;

  logic [ALU_W-1:0] b_eff;
  logic [ALU_W-1:0] sum;

  assign b_eff    = op.inv_b ? ~b : b;
  assign sum      = a + b_eff + {{(ALU_W-1){1'b0}}, op.cin};
  assign res.sum  = sum;
  assign res.neg  = sum[ALU_W-1];
  assign res.zero = (sum == '0);

endmodule

>>> hw/rtl/ssnap_core.sv
// Sequencer, gesture state and working registers around the shared ALU.
`timescale 1ns / 1ps
module ssnap_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     go,
  input  ssnap_pkg::ssnap_item_t   item,
  input  ssnap_pkg::ssnap_cfg_t    cfg,
  output logic                     core_busy,
  output logic                     emit,
  output ssnap_pkg::ssnap_result_t res
);
  import ssnap_pkg::*;
  `include "scroll_snap_select_unit_assert.svh"

  ssnap_state_t state, state_next;

  // gesture state
  logic signed [23:0] cur_reg, want_reg, port_top_reg, port_bottom_reg;
  logic [22:0]        clamp_max;
  logic [1:0]         mode_bits;
  logic signed [23:0] best_pos, stop_pos;
  logic [24:0]        best_dist, stop_dist;
  logic               have_best, have_stop;

  // working registers
  logic signed [ALU_W-1:0] acc, tmp;
  logic [22:0]             cand;
  logic signed [24:0]      moved, travel;
  logic [MUL_CNT_W-1:0]    mul_cnt;

  logic signed [ALU_W-1:0] alu_a, alu_b;
  ssnap_alu_op_t           alu_op;
  ssnap_alu_res_t          alu;
  logic                    path_ok;
  logic                    port_ok;
  logic [7:0]              den_eff;
  logic [2:0]              bit_idx;

  ssnap_alu u_alu (
    .a  (alu_a),
    .b  (alu_b),
    .op (alu_op),
    .res(alu)
  );

  assign core_busy = (state != ST_IDLE);
  assign den_eff   = (cfg.proximity_den == '0) ? 8'd1 : cfg.proximity_den;
  assign bit_idx   = mul_cnt[2:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    alu_a      = '0;
    alu_b      = '0;
    alu_op     = OP_ADD;
    emit       = 1'b0;
    res        = '0;
    path_ok    = 1'b0;
    port_ok    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (go) begin
          case (item.func)
            FUNC_BEGIN:  state_next = ST_BEGIN;
            FUNC_CAND:   state_next = ST_C_DELTA;
            FUNC_FINISH: state_next = ST_F_H;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_BEGIN: begin
        alu_a      = zext23(item.scroll_range);
        alu_b      = zext23(cfg.scroll_limit);
        alu_op     = OP_SUB;
        state_next = ST_IDLE;
      end
      ST_C_DELTA: begin
        case (item.align)
          ALIGN_START: begin
            alu_a      = sext24(item.box_top);
            alu_b      = sext24(port_top_reg);
            alu_op     = OP_SUB;
            state_next = ST_C_CAND;
          end
          ALIGN_END: begin
            alu_a      = sext24(item.box_bottom);
            alu_b      = sext24(port_bottom_reg);
            alu_op     = OP_SUB;
            state_next = ST_C_CAND;
          end
          ALIGN_CENTER: begin
            alu_a      = sext24(item.box_top);
            alu_b      = sext24(item.box_bottom);
            state_next = ST_C_H1;
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_C_H1, ST_C_H2: begin
        // bias negatives by one so the shift truncates toward zero
        alu_a      = acc;
        alu_op     = '{inv_b: 1'b0, cin: acc[ALU_W-1]};
        state_next = (state == ST_C_H1) ? ST_C_U : ST_C_D;
      end
      ST_C_U: begin
        alu_a      = sext24(port_top_reg);
        alu_b      = sext24(port_bottom_reg);
        state_next = ST_C_H2;
      end
      ST_C_D: begin
        alu_a      = tmp;
        alu_b      = acc;
        alu_op     = OP_SUB;
        state_next = ST_C_CAND;
      end
      ST_C_CAND: begin
        alu_a      = sext24(cur_reg);
        alu_b      = acc;
        state_next = ST_C_CLAMP;
      end
      ST_C_CLAMP: begin
        alu_a      = acc;
        alu_b      = zext23(clamp_max);
        alu_op     = OP_SUB;
        state_next = ST_C_DIST;
      end
      ST_C_DIST: begin
        alu_a      = zext23(cand);
        alu_b      = sext24(want_reg);
        alu_op     = OP_SUB;
        state_next = ST_C_ABS;
      end
      ST_C_ABS: begin
        alu_b      = acc;
        alu_op     = OP_SUB;
        state_next = ST_C_BEST;
      end
      ST_C_BEST: begin
        alu_a      = acc;
        alu_b      = zext25(best_dist);
        alu_op     = OP_SUB;
        state_next = ST_C_MOVE;
      end
      ST_C_MOVE: begin
        alu_a      = sext24(want_reg);
        alu_b      = sext24(cur_reg);
        alu_op     = OP_SUB;
        state_next = ST_C_TRAV;
      end
      ST_C_TRAV: begin
        alu_a      = zext23(cand);
        alu_b      = sext24(cur_reg);
        alu_op     = OP_SUB;
        state_next = ST_C_PATH;
      end
      ST_C_PATH: begin
        // travel must not overshoot the move, compared by magnitude
        alu_a   = moved[24] ? sext25(travel) : sext25(moved);
        alu_b   = moved[24] ? sext25(moved) : sext25(travel);
        alu_op  = OP_SUB;
        path_ok = item.stop_always && (moved != '0) && (travel != '0) &&
                  (moved[24] == travel[24]) && !alu.neg;
        state_next = path_ok ? ST_C_TABS : ST_IDLE;
      end
      ST_C_TABS: begin
        alu_b      = sext25(travel);
        alu_op     = OP_SUB;
        state_next = ST_C_STOP;
      end
      ST_C_STOP: begin
        alu_a      = acc;
        alu_b      = zext25(stop_dist);
        alu_op     = OP_SUB;
        state_next = ST_IDLE;
      end
      ST_F_H: begin
        alu_a   = sext24(port_bottom_reg);
        alu_b   = sext24(port_top_reg);
        alu_op  = OP_SUB;
        port_ok = mode_bits[0] && !alu.neg && !alu.zero;
        res     = '{settled_offset: want_reg, outcome: OUT_KEPT};
        if (!port_ok || (!have_stop && !have_best)) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end else if (have_stop) begin
          emit       = 1'b1;
          res        = '{settled_offset: stop_pos, outcome: OUT_STOP};
          state_next = ST_IDLE;
        end else if (mode_bits[1]) begin
          emit       = 1'b1;
          res        = '{settled_offset: best_pos, outcome: OUT_SNAP};
          state_next = ST_IDLE;
        end else begin
          state_next = ST_F_MUL;
        end
      end
      ST_F_MUL: begin
        // tmp accumulates port_h*num - best_dist*den; snap when it ends non-negative
        alu_a = tmp;
        if (!mul_cnt[MUL_CNT_W-1]) begin
          alu_b = cfg.proximity_num[bit_idx] ? (acc << bit_idx) : '0;
        end else begin
          alu_b  = den_eff[bit_idx] ? (zext25(best_dist) << bit_idx) : '0;
          alu_op = OP_SUB;
        end
        if (mul_cnt == MUL_LAST) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
          if (alu.neg) begin
            res = '{settled_offset: want_reg, outcome: OUT_KEPT};
          end else begin
            res = '{settled_offset: best_pos, outcome: OUT_SNAP};
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_reg         <= '0;
      want_reg        <= '0;
      port_top_reg    <= '0;
      port_bottom_reg <= '0;
      clamp_max       <= '0;
      mode_bits       <= '0;
      best_pos        <= '0;
      best_dist       <= '0;
      have_best       <= 1'b0;
      stop_pos        <= '0;
      stop_dist       <= '0;
      have_stop       <= 1'b0;
      mul_cnt         <= '0;
    end else begin
      case (state)
        ST_BEGIN: begin
          cur_reg         <= item.cur_offset;
          want_reg        <= item.want_offset;
          port_top_reg    <= item.view_top;
          port_bottom_reg <= item.view_bottom;
          clamp_max       <= alu.neg ? item.scroll_range : cfg.scroll_limit;
          mode_bits       <= {item.mandatory, item.snap_on};
          best_pos        <= '0;
          best_dist       <= '0;
          have_best       <= 1'b0;
          stop_pos        <= '0;
          stop_dist       <= '0;
          have_stop       <= 1'b0;
        end
        ST_C_DELTA, ST_C_U, ST_C_D, ST_C_CAND, ST_C_DIST: acc <= alu.sum;
        ST_C_H1:   tmp <= half(alu.sum);
        ST_C_H2:   acc <= half(alu.sum);
        ST_C_CLAMP: begin
          if (acc[ALU_W-1]) begin
            cand <= '0;
          end else if (!alu.neg && !alu.zero) begin
            cand <= clamp_max;
          end else begin
            cand <= acc[22:0];
          end
        end
        ST_C_ABS:  acc <= acc[ALU_W-1] ? alu.sum : acc;
        ST_C_BEST: begin
          if (!have_best || alu.neg) begin
            best_pos  <= {1'b0, cand};
            best_dist <= acc[24:0];
            have_best <= 1'b1;
          end
        end
        ST_C_MOVE: moved  <= alu.sum[24:0];
        ST_C_TRAV: travel <= alu.sum[24:0];
        ST_C_TABS: acc    <= travel[24] ? alu.sum : sext25(travel);
        ST_C_STOP: begin
          if (!have_stop || alu.neg) begin
            stop_pos  <= {1'b0, cand};
            stop_dist <= acc[24:0];
            have_stop <= 1'b1;
          end
        end
        ST_F_H: begin
          acc     <= alu.sum;
          tmp     <= '0;
          mul_cnt <= '0;
        end
        ST_F_MUL: begin
          tmp     <= alu.sum;
          mul_cnt <= mul_cnt + 1'b1;
        end
        default: ;
      endcase
    end
  end

  `SSNAP_ASSERT_NOW(a_mul_end_emits, clk, rst,
    (state == ST_F_MUL && mul_cnt == MUL_LAST), emit, "last MAC step did not emit")
  `SSNAP_ASSERT_NOW(a_best_clear_on_begin, clk, rst,
    $fell(have_best), ($past(state) == ST_BEGIN), "nearest snap lost outside begin")
  `SSNAP_ASSERT_NEXT(a_best_dist_shrinks, clk, rst,
    (state == ST_C_BEST && have_best), (best_dist <= $past(best_dist)),
    "tracked snap distance grew")

endmodule

>>> hw/rtl/scroll_snap_select_unit.sv
// Top level: command port, configuration registers and result register.
`timescale 1ns / 1ps
//
//  channel   | signals                          | transfer when
//  ----------+----------------------------------+-----------------------------
//  command   | start, busy, item                | start high while busy low
//  result    | done, result                     | done high (one cycle only)
//  config    | cfg_we, cfg_index, cfg_data      | cfg_we high
//
//  Steps: begin compares range with limit and loads the gesture state; a
//  candidate runs more steps for center alignment than for start/end and
//  stops after the path test when it fails; finish runs, in proximity mode,
//  a fraction test of 16 shift-add steps through the single shared adder.
//  done rises the cycle after the last step. Reset clears the sequencer,
//  the gesture state and the config registers to their defaults; no clearing
//  pass. The receiver cannot stall: done is high for one cycle only.
//
//  Candidate steps: align, clamp cur+delta to [0, min(range, limit)],
//  |cand - want| against the nearest snap, then the path test and
//  |cand - cur| against the nearest stop-always box.
//  Proximity: distance <= floor(port_h*num/den) is tested as
//  port_h*num - distance*den >= 0, so no divider is needed.
module scroll_snap_select_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  ssnap_pkg::ssnap_item_t                item,
  output logic                                  done,
  output ssnap_pkg::ssnap_result_t              result,
  input  logic                                  cfg_we,
  input  logic [ssnap_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ssnap_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import ssnap_pkg::*;

  ssnap_cfg_t    cfg;
  ssnap_item_t   item_reg;
  logic          go;
  logic          core_busy;
  logic          emit;
  ssnap_result_t core_res;

  // busy covers the hand-off cycle as well as the sequencer
  assign busy = go | core_busy;

  // command transfer: hold the item for the whole run
  always_ff @(posedge clk) begin
    if (rst) begin
      go <= 1'b0;
    end else begin
      go <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_reg <= item;
    end
  end

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scroll_limit  <= LIMIT_RESET;
      cfg.proximity_num <= NUM_RESET;
      cfg.proximity_den <= DEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCROLL_LIMIT:  cfg.scroll_limit  <= cfg_data;
        CFG_PROXIMITY_NUM: cfg.proximity_num <= cfg_data[7:0];
        CFG_PROXIMITY_DEN: cfg.proximity_den <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  ssnap_core u_core (
    .clk      (clk),
    .rst      (rst),
    .go       (go),
    .item     (item_reg),
    .cfg      (cfg),
    .core_busy(core_busy),
    .emit     (emit),
    .res      (core_res)
  );

  // result register: one-cycle strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= core_res;
    end
  end

endmodule
